>>> sv/i2cmls_pkg.sv
// package for the i2c master line sequencer: command codes, widths and
// constants shared by the sequencer rtl
// no dependencies
`default_nettype none

package i2cmls_pkg;

    localparam int unsigned BITS_PER_BYTE = 8;
    localparam int unsigned BIT_IDX_W     = $clog2(BITS_PER_BYTE);
    localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_BYTE - 1);

    localparam int unsigned FUNC_W   = 3;
    localparam int unsigned PHASE_W  = 2;
    localparam int unsigned S_USER_W = 1 + FUNC_W;
    localparam int unsigned S_DATA_W = 16;
    localparam int unsigned M_DATA_W = 16;

    typedef enum logic [FUNC_W-1:0] {
        OP_START     = 3'd0,
        OP_STOP      = 3'd1,
        OP_SEND_BYTE = 3'd2,
        OP_RECV_BYTE = 3'd3,
        OP_SEND_ACK  = 3'd4,
        OP_RECV_ACK  = 3'd5
    } op_t;

    localparam logic [PHASE_W-1:0] PH_0 = 2'd0;
    localparam logic [PHASE_W-1:0] PH_1 = 2'd1;
    localparam logic [PHASE_W-1:0] PH_2 = 2'd2;

endpackage

`default_nettype wire

>>> sv/i2c_master_line_sequencer_unit.sv
// i2c master line sequencer: one scl/sda line change per input transaction
// depends on i2cmls_pkg
`default_nettype none

//  channel  | direction | tdata (low bit up)                           | tuser
//  ---------+-----------+----------------------------------------------+---------------------
//  s_axis   | in        | tx_byte[7:0], ack_to_send, sda_in, zero pad | cmd_valid, func[2:0]
//  m_axis   | out       | scl_out, sda_out, busy_res, done_res,       | -
//           |           | rx_byte[7:0], rx_ack, zero pad               |
//
// one transaction per clock sustained while the output is not stalled; a
// transaction's result passes from the input register through the sequencer
// step into the output register. the sequencer state is updated in the same
// step, so each tick sees the state left by the one before. reset (rst_n low,
// async) releases both lines and leaves the sequencer idle. a stalled output
// holds its result; the input register still takes one transaction
// meanwhile.

module i2c_master_line_sequencer_unit
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // tx_byte[7:0], ack_to_send[8], sda_in[9], zeros above
    input  wire logic [i2cmls_pkg::S_DATA_W-1:0]   s_tdata,
    // cmd_valid[0], func[3:1]
    input  wire logic [i2cmls_pkg::S_USER_W-1:0]   s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // scl_out[0], sda_out[1], busy_res[2], done_res[3], rx_byte[11:4], rx_ack[12]
    output logic [i2cmls_pkg::M_DATA_W-1:0]        m_tdata
);
    import i2cmls_pkg::*;

    // input stage
    logic                   in_vld_reg;
    logic [S_USER_W-1:0]    in_user_reg;
    logic [9:0]             in_data_reg;

    // output stage
    logic                   out_vld_reg;
    logic [M_DATA_W-1:0]    out_data_reg;

    // sequencer state
    logic                   scl_reg,   scl_next;
    logic                   sda_reg,   sda_next;
    op_t                    op_reg,    op_next;
    logic                   busy_reg,  busy_next;
    logic [PHASE_W-1:0]     phase_reg, phase_next;
    logic [BIT_IDX_W-1:0]   bit_reg,   bit_next;
    logic [7:0]             shift_reg, shift_next;
    logic                   ack_reg,   ack_next;
    logic [7:0]             rx_reg,    rx_next;
    logic                   done_next;

    logic                   out_free;
    logic                   step_en;

    logic                   cmd_valid;
    logic [FUNC_W-1:0]      func;
    logic [7:0]             tx_byte;
    logic                   ack_to_send;
    logic                   sda_in;

    logic                   begin_cmd;
    logic [PHASE_W-1:0]     eff_phase;
    logic [BIT_IDX_W-1:0]   eff_bit;
    logic [BIT_IDX_W-1:0]   bit_pos;
    logic [7:0]             eff_shift;
    logic [7:0]             sampled;
    logic                   fin;
    logic                   adv;

    assign out_free = !out_vld_reg || m_tready;
    assign step_en  = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || step_en;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    assign cmd_valid   = in_user_reg[0];
    assign func        = in_user_reg[S_USER_W-1:1];
    assign tx_byte     = in_data_reg[7:0];
    assign ack_to_send = in_data_reg[8];
    assign sda_in      = in_data_reg[9];

    assign begin_cmd = !busy_reg && cmd_valid && (func <= OP_RECV_ACK);
    assign eff_phase = begin_cmd ? PH_0 : phase_reg;
    assign eff_bit   = begin_cmd ? '0 : bit_reg;
    assign bit_pos   = LAST_BIT - eff_bit;   // msb first

    always_comb
    begin
        if (!begin_cmd)
        begin
            eff_shift = shift_reg;
        end
        else if (func == OP_SEND_BYTE)
        begin
            eff_shift = tx_byte;
        end
        else if (func == OP_SEND_ACK)
        begin
            eff_shift = {ack_to_send, 7'b0};
        end
        else
        begin
            eff_shift = '0;
        end
    end

    always_comb
    begin
        sampled          = eff_shift;
        sampled[bit_pos] = eff_shift[bit_pos] | sda_in;
    end

    always_comb
    begin
        op_next    = begin_cmd ? op_t'(func) : op_reg;
        busy_next  = begin_cmd || busy_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        phase_next = eff_phase;
        bit_next   = eff_bit;
        shift_next = eff_shift;
        ack_next   = ack_reg;
        rx_next    = rx_reg;
        fin        = 1'b0;
        adv        = 1'b0;

        if (busy_next)
        begin
            unique case (op_next)
                OP_START:
                begin
                    priority if (eff_phase == PH_0)
                    begin
                        sda_next = 1'b1;
                        adv      = 1'b1;
                    end
                    else if (eff_phase == PH_1)
                    begin
                        scl_next = 1'b1;
                        adv      = 1'b1;
                    end
                    else if (eff_phase == PH_2)
                    begin
                        sda_next = 1'b0;
                        adv      = 1'b1;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                        fin      = 1'b1;
                    end
                end
                OP_STOP:
                begin
                    priority if (eff_phase == PH_0)
                    begin
                        sda_next = 1'b0;
                        adv      = 1'b1;
                    end
                    else if (eff_phase == PH_1)
                    begin
                        scl_next = 1'b1;
                        adv      = 1'b1;
                    end
                    else
                    begin
                        sda_next = 1'b1;
                        fin      = 1'b1;
                    end
                end
                OP_SEND_BYTE, OP_SEND_ACK:
                begin
                    priority if (eff_phase == PH_0)
                    begin
                        sda_next = eff_shift[bit_pos];
                        adv      = 1'b1;
                    end
                    else if (eff_phase == PH_1)
                    begin
                        scl_next = 1'b1;
                        adv      = 1'b1;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                        if (op_next == OP_SEND_ACK || eff_bit == LAST_BIT)
                        begin
                            fin = 1'b1;
                        end
                        else
                        begin
                            bit_next   = eff_bit + 1'b1;
                            phase_next = PH_0;
                        end
                    end
                end
                OP_RECV_BYTE:
                begin
                    priority if (eff_phase == PH_0)
                    begin
                        sda_next = 1'b1;
                        adv      = 1'b1;
                    end
                    else if (eff_phase == PH_1)
                    begin
                        scl_next = 1'b1;
                        adv      = 1'b1;
                    end
                    else
                    begin
                        // sample the bit and drop scl in the same tick
                        shift_next = sampled;
                        scl_next   = 1'b0;
                        if (eff_bit == LAST_BIT)
                        begin
                            rx_next = sampled;
                            fin     = 1'b1;
                        end
                        else
                        begin
                            bit_next   = eff_bit + 1'b1;
                            phase_next = PH_1;
                        end
                    end
                end
                OP_RECV_ACK:
                begin
                    priority if (eff_phase == PH_0)
                    begin
                        sda_next = 1'b1;
                        adv      = 1'b1;
                    end
                    else if (eff_phase == PH_1)
                    begin
                        scl_next = 1'b1;
                        adv      = 1'b1;
                    end
                    else
                    begin
                        ack_next = sda_in;
                        scl_next = 1'b0;
                        fin      = 1'b1;
                    end
                end
                default:
                begin
                    fin = 1'b1;
                end
            endcase

            if (adv)
            begin
                phase_next = eff_phase + 1'b1;
            end
            if (fin)
            begin
                busy_next  = 1'b0;
                phase_next = PH_0;
                bit_next   = '0;
            end
        end
    end

    assign done_next = fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            op_reg      <= OP_START;
            busy_reg    <= 1'b0;
            phase_reg   <= PH_0;
            bit_reg     <= '0;
            shift_reg   <= '0;
            ack_reg     <= 1'b1;
            rx_reg      <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_vld_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_vld_reg <= in_vld_reg;
            end
            if (step_en)
            begin
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                op_reg    <= op_next;
                busy_reg  <= busy_next;
                phase_reg <= phase_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                ack_reg   <= ack_next;
                rx_reg    <= rx_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_user_reg <= s_tuser;
            in_data_reg <= s_tdata[9:0];
        end
        if (step_en)
        begin
            out_data_reg <= {3'b0, ack_next, rx_next, done_next, busy_next,
                             sda_next, scl_next};
        end
    end

    // a finished sequence never reports busy on the same tick
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[3] && m_tdata[2]))
        else $error("done and busy reported together");

    // the bit counter only moves during a byte transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (bit_reg != '0) |-> (busy_reg && (op_reg == OP_SEND_BYTE || op_reg == OP_RECV_BYTE)))
        else $error("bit index set outside a byte transfer");

    // only a start sequence ever reaches its fourth phase
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == 2'd3) |-> (busy_reg && op_reg == OP_START))
        else $error("fourth phase outside a start sequence");

    // state holds while the step is stalled
    assert property (@(posedge clk) disable iff (!rst_n)
        !step_en |=> ($stable(busy_reg) && $stable(phase_reg) && $stable(scl_reg)))
        else $error("sequencer state moved without a step");

endmodule

`default_nettype wire
